/* design/tvpt_pkg.sv */
// package of types, constants and codes for the thermal video packet tracker
package tvpt_pkg;

  localparam int ADDR_BITS     = 14;
  localparam int PACKET_BYTES  = 164;
  localparam int RESYNC_BITS   = 11;
  localparam int POS_BITS      = $clog2(PACKET_BYTES + 1);
  localparam int CFG_DATA_BITS = (ADDR_BITS > RESYNC_BITS) ? ADDR_BITS : RESYNC_BITS;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_BUFFER_LAST = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RESYNC      = 1'd1;

  localparam logic [ADDR_BITS-1:0]   BUFFER_LAST_RESET = ADDR_BITS'(12287);
  localparam logic [RESYNC_BITS-1:0] RESYNC_RESET      = RESYNC_BITS'(1562);

  localparam logic [POS_BITS-1:0] POS_NONE       = POS_BITS'(PACKET_BYTES);
  localparam logic [POS_BITS-1:0] POS_LAST       = POS_BITS'(PACKET_BYTES - 1);
  localparam logic [POS_BITS-1:0] POS_HDR_PACKET = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] POS_FIRST_DATA = POS_BITS'(5);

  localparam logic [3:0] DISCARD_NIBBLE  = 4'hF;
  localparam logic [7:0] TRIGGER_PKT     = 8'd20;
  localparam logic [5:0] TRIGGER_PKT_NUM = 6'd20;
  localparam logic [5:0] PRE_TRIGGER_PKT = 6'd19;
  localparam logic [5:0] LAST_PKT_NUM    = 6'd59;
  localparam logic [2:0] TRIGGER_SEG     = 3'd1;
  localparam logic [2:0] LAST_SEG        = 3'd4;

  localparam logic [1:0] ST_DISCARD = 2'd0;
  localparam logic [1:0] ST_GOOD    = 2'd1;
  localparam logic [1:0] ST_TRIGGER = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       first_byte;
    logic       enable;
    logic       consumer_idle;
    logic       consumer_in_frame;
  } byte_item_t;

  typedef struct packed {
    logic                 store_valid;
    logic [ADDR_BITS-1:0] store_address;
    logic [7:0]           store_byte;
    logic                 packet_done;
    logic [1:0]           packet_status;
    logic                 start_consumer;
    logic                 abort_consumer;
    logic                 frame_led;
    logic                 chip_select_active;
    logic                 resync_request;
  } result_item_t;

endpackage

/* design/tvpt_core.sv */
// packet tracking state and per-byte result logic
module tvpt_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  tvpt_pkg::byte_item_t            item,
  input  logic [tvpt_pkg::ADDR_BITS-1:0]  buffer_last_address,
  input  logic [tvpt_pkg::RESYNC_BITS-1:0] resync_packets,
  output tvpt_pkg::result_item_t          result
);
  import tvpt_pkg::*;

  typedef enum logic [1:0] {MODE_STOPPED, MODE_DATA, MODE_WAIT} mode_t;

  mode_t                  run_mode, run_mode_next;
  logic [POS_BITS-1:0]    byte_position, byte_position_next;
  logic [7:0]             header_high, header_high_next;
  logic [7:0]             header_packet, header_packet_next;
  logic                   storing_packet, storing_packet_next;
  logic [2:0]             expected_segment, expected_segment_next;
  logic [5:0]             last_packet_number, last_packet_number_next;
  logic [ADDR_BITS-1:0]   write_address, write_address_next;
  logic [RESYNC_BITS-1:0] packets_since_trigger, packets_since_trigger_next;
  logic                   led_on, led_on_next;
  logic [POS_BITS-1:0]    pos;
  logic [2:0]             seg;

  assign seg = header_high[6:4];

  always_comb begin
    run_mode_next              = run_mode;
    byte_position_next         = byte_position;
    header_high_next           = header_high;
    header_packet_next         = header_packet;
    storing_packet_next        = storing_packet;
    expected_segment_next      = expected_segment;
    last_packet_number_next    = last_packet_number;
    write_address_next         = write_address;
    packets_since_trigger_next = packets_since_trigger;
    led_on_next                = led_on;
    result                     = '0;

    if (item.first_byte) begin
      if (item.enable) begin
        if (run_mode == MODE_STOPPED) begin
          run_mode_next              = MODE_DATA;
          write_address_next         = '0;
          expected_segment_next      = '0;
          last_packet_number_next    = LAST_PKT_NUM;
          packets_since_trigger_next = '0;
        end
      end else if (run_mode != MODE_STOPPED) begin
        run_mode_next = MODE_STOPPED;
        led_on_next   = 1'b0;
      end
      if (run_mode_next == MODE_WAIT && item.consumer_idle) begin
        run_mode_next              = MODE_DATA;
        write_address_next         = '0;
        expected_segment_next      = '0;
        last_packet_number_next    = LAST_PKT_NUM;
        packets_since_trigger_next = '0;
      end
      byte_position_next = (run_mode_next == MODE_STOPPED) ? POS_NONE : '0;
    end

    pos = byte_position_next;
    if (pos < POS_NONE) begin
      if (pos == '0) begin
        header_high_next    = item.spi_byte;
        storing_packet_next = !(item.spi_byte[3:0] == DISCARD_NIBBLE ||
                                run_mode_next == MODE_WAIT);
      end else if (pos == POS_HDR_PACKET) begin
        header_packet_next = item.spi_byte;
      end else if (pos >= POS_FIRST_DATA && pos[0] && storing_packet) begin
        result.store_valid   = 1'b1;
        result.store_address = write_address_next;
        result.store_byte    = item.spi_byte;
        write_address_next   = write_address_next + 1'b1;
        if (write_address_next > buffer_last_address) begin
          write_address_next = '0;
        end
      end

      if (pos == POS_LAST) begin
        result.packet_done = 1'b1;
        if (!storing_packet) begin
          result.packet_status = ST_DISCARD;
        end else if (header_packet == TRIGGER_PKT) begin
          if ({1'b0, expected_segment_next} + 4'd1 != {1'b0, seg}) begin
            result.packet_status = ST_ILLEGAL;
          end else begin
            expected_segment_next = seg;
            if (last_packet_number_next != PRE_TRIGGER_PKT) begin
              result.packet_status = ST_ILLEGAL;
            end else begin
              last_packet_number_next = TRIGGER_PKT_NUM;
              result.packet_status = (seg == TRIGGER_SEG) ? ST_TRIGGER : ST_GOOD;
            end
          end
        end else if (last_packet_number_next == LAST_PKT_NUM) begin
          if (header_packet != 8'd0) begin
            result.packet_status = ST_ILLEGAL;
          end else begin
            last_packet_number_next = '0;
            result.packet_status    = ST_GOOD;
          end
        end else if ({2'b00, last_packet_number_next} + 8'd1 != header_packet) begin
          result.packet_status = ST_ILLEGAL;
        end else begin
          last_packet_number_next = header_packet[5:0];
          result.packet_status    = ST_GOOD;
        end

        packets_since_trigger_next = packets_since_trigger_next + 1'b1;
        case (result.packet_status)
          ST_ILLEGAL: begin
            result.abort_consumer   = item.consumer_in_frame;
            write_address_next      = '0;
            expected_segment_next   = '0;
            last_packet_number_next = LAST_PKT_NUM;
            led_on_next             = 1'b0;
          end
          ST_TRIGGER: begin
            result.start_consumer      = 1'b1;
            packets_since_trigger_next = '0;
            led_on_next                = 1'b1;
          end
          ST_GOOD: begin
            if (last_packet_number_next == LAST_PKT_NUM &&
                expected_segment_next == LAST_SEG) begin
              run_mode_next = MODE_WAIT;
              led_on_next   = 1'b0;
            end
          end
          default: begin
          end
        endcase
        if (packets_since_trigger_next == resync_packets) begin
          result.resync_request      = 1'b1;
          led_on_next                = 1'b0;
          write_address_next         = '0;
          expected_segment_next      = '0;
          last_packet_number_next    = LAST_PKT_NUM;
          packets_since_trigger_next = '0;
        end
        byte_position_next = POS_NONE;
      end else begin
        byte_position_next = pos + 1'b1;
      end
    end

    result.frame_led          = led_on_next;
    result.chip_select_active = (run_mode_next != MODE_STOPPED);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode              <= MODE_STOPPED;
      byte_position         <= POS_NONE;
      header_high           <= '0;
      header_packet         <= '0;
      storing_packet        <= 1'b0;
      expected_segment      <= '0;
      last_packet_number    <= LAST_PKT_NUM;
      write_address         <= '0;
      packets_since_trigger <= '0;
      led_on                <= 1'b0;
    end else if (take) begin
      run_mode              <= run_mode_next;
      byte_position         <= byte_position_next;
      header_high           <= header_high_next;
      header_packet         <= header_packet_next;
      storing_packet        <= storing_packet_next;
      expected_segment      <= expected_segment_next;
      last_packet_number    <= last_packet_number_next;
      write_address         <= write_address_next;
      packets_since_trigger <= packets_since_trigger_next;
      led_on                <= led_on_next;
    end
  end

endmodule

/* design/tvpt_skid.sv */
// result register with a one-entry skid stage
module tvpt_skid (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tvpt_pkg::result_item_t push_data,
  output logic                   full,
  output logic                   result_valid,
  input  logic                   result_stall,
  output tvpt_pkg::result_item_t result
);
  import tvpt_pkg::*;

  logic         skid_valid;
  result_item_t skid_data;
  logic         out_free;

  assign out_free = !result_valid || !result_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      result_valid <= skid_valid || push;
      skid_valid   <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      result <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* design/thermal_video_packet_tracker.sv */
// top level of the thermal video packet tracker
// takes one camera link byte per request on the byte channel and returns one
// result per byte on the result channel: the buffer write for the byte, and at
// the last byte of a packet its status and the consumer, led, chip select and
// resync signals
// a request is taken at a clock edge with byte_valid high and byte_stall low;
// a result is taken at an edge with result_valid high and result_stall low
// the result is registered; one byte is taken every cycle while byte_stall is
// low, set by the single state update per byte in the tracker logic
// when the receiver stalls, the result register holds and a one-entry skid
// stage takes one more result; byte_stall is then high until it drains
// configuration: cfg_write_en with cfg_index 0 writes the buffer last address,
// index 1 the resync packet count; write only while the block is idle
// synchronous reset stops capture, closes any packet, clears the result
// channel and sets both configuration registers to their defaults
module thermal_video_packet_tracker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  tvpt_pkg::byte_item_t               byte_data,
  output logic                               result_valid,
  input  logic                               result_stall,
  output tvpt_pkg::result_item_t             result,
  input  logic                               cfg_write_en,
  input  logic [tvpt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tvpt_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import tvpt_pkg::*;

  logic [ADDR_BITS-1:0]   buffer_last_address;
  logic [RESYNC_BITS-1:0] resync_packets;
  logic                   take;
  logic                   skid_full;
  result_item_t           core_result;

  assign take       = byte_valid && !skid_full;
  assign byte_stall = skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_last_address <= BUFFER_LAST_RESET;
      resync_packets      <= RESYNC_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_BUFFER_LAST: buffer_last_address <= cfg_data[ADDR_BITS-1:0];
        CFG_RESYNC:      resync_packets      <= cfg_data[RESYNC_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  tvpt_core u_core (
    .clk                 (clk),
    .rst                 (rst),
    .take                (take),
    .item                (byte_data),
    .buffer_last_address (buffer_last_address),
    .resync_packets      (resync_packets),
    .result              (core_result)
  );

  tvpt_skid u_skid (
    .clk          (clk),
    .rst          (rst),
    .push         (take),
    .push_data    (core_result),
    .full         (skid_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid)
    else $error("skid entry held without a result on the output");

  a_status_needs_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.packet_done || result.packet_status == ST_DISCARD))
    else $error("packet status without packet done");

  a_start_on_trigger: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.start_consumer |-> result.packet_status == ST_TRIGGER)
    else $error("start consumer without trigger status");

  a_abort_on_illegal: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.abort_consumer |-> result.packet_status == ST_ILLEGAL)
    else $error("abort consumer without illegal status");

  a_reset_clears_skid: assert property (@(posedge clk)
    !rst && $past(rst) |-> !byte_stall && !result_valid)
    else $error("result channel not empty after reset");
`endif

endmodule
